/* src/rvwap_pkg.sv */
// Shared types and constants for the rolling VWAP band core.
`default_nettype none
package rvwap_pkg;
    localparam int unsigned RING_DEPTH = 256;
    localparam int unsigned RING_AW    = 8;
    localparam int unsigned CNT_W      = 9;
    localparam int unsigned PRICE_W    = 24;
    localparam int unsigned VOL_W      = 24;
    localparam int unsigned TP_W       = 32;
    localparam int unsigned PSUM_W     = 26;
    localparam int unsigned WSUM_W     = 64;
    localparam int unsigned VSUM_W     = 32;
    localparam int unsigned ACC_W      = 96;
    localparam int unsigned BAND_W     = 35;
    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 248;
    localparam int unsigned ENTRY_W    = TP_W + VOL_W;

    localparam logic [CNT_W-1:0] WIN_RESET = 9'd20;
    localparam logic [CNT_W-1:0] WIN_MAX   = 9'd256;
    localparam logic [CNT_W-1:0] DIV_LAST  = 9'd63;

    // floor(256*s/3) = 85*s + floor(s/3); floor(s/3) by reciprocal for s < 2^26
    localparam logic [33:0] TP_MUL     = 34'd85;
    localparam logic [26:0] DIV3_MUL   = 27'd89478486;
    localparam int unsigned DIV3_SHIFT = 28;

    typedef struct packed {
        logic              start;
        logic [TP_W-1:0]   tp;
        logic [VOL_W-1:0]  vol;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage
`default_nettype wire

/* src/rvwap_front.sv */
// Front end: accepts bars and forms the typical price.
`default_nettype none
module rvwap_front (
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rvwap_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  rvwap_pkg::t_q_stat                i_q_stat,
    output logic                              o_push,
    output rvwap_pkg::t_item                  o_item
);
    import rvwap_pkg::*;

    logic [PSUM_W-1:0] psum;
    logic [52:0]       q3_prod;
    logic [33:0]       m85;
    logic [33:0]       tp_full;

    always_comb begin
        psum = {2'b0, s_axis_tdata[23:0]} + {2'b0, s_axis_tdata[47:24]}
             + {2'b0, s_axis_tdata[71:48]};
        q3_prod = {27'b0, psum} * {26'b0, DIV3_MUL};
        m85 = {8'b0, psum} * TP_MUL;
        tp_full = m85 + {9'b0, q3_prod[52:DIV3_SHIFT]};
    end

    assign s_axis_tready = !i_q_stat.full;
    assign o_push        = s_axis_tvalid && !i_q_stat.full;
    assign o_item.start  = s_axis_tuser;
    assign o_item.tp     = tp_full[TP_W-1:0];
    assign o_item.vol    = s_axis_tdata[95:72];
endmodule
`default_nettype wire

/* src/rvwap_fifo.sv */
// Two-entry queue between front end and back end.
`default_nettype none
module rvwap_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rvwap_pkg::t_item   i_item,
    input  logic               i_pop,
    output rvwap_pkg::t_item   o_item,
    output rvwap_pkg::t_q_stat o_stat
);
    import rvwap_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
endmodule
`default_nettype wire

/* src/rvwap_back.sv */
// Back end: ring, running sums, variance walk, divider, square root, bands.
`default_nettype none
module rvwap_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [rvwap_pkg::CNT_W-1:0]        i_win,
    input  rvwap_pkg::t_item                   i_item,
    input  rvwap_pkg::t_q_stat                 i_q_stat,
    output logic                               o_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rvwap_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import rvwap_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EVRD = 9'b000000010,
        S_EVUP = 9'b000000100,
        S_WR   = 9'b000001000,
        S_DIV1 = 9'b000010000,
        S_WALK = 9'b000100000,
        S_DIV2 = 9'b001000000,
        S_SQRT = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [ENTRY_W-1:0]  r_ring [RING_DEPTH];
    logic [ENTRY_W-1:0]  r_rdata;
    logic [RING_AW-1:0]  rd_addr;
    t_item               r_item;
    logic [CNT_W-1:0]    r_size;
    logic [WSUM_W-1:0]   r_wsum;
    logic [VSUM_W-1:0]   r_vsum;
    logic [CNT_W-1:0]    r_fill;
    logic [RING_AW-1:0]  r_wpos;
    logic [CNT_W-1:0]    r_cnt;
    logic [31:0]         r_rem;
    logic [63:0]         r_dq;
    logic [TP_W-1:0]     r_vwap;
    logic [31:0]         r_dev;
    logic                r_v1, r_v2, r_v3;
    logic [63:0]         r_sq;
    logic [VOL_W-1:0]    r_vol2;
    logic [55:0]         r_plo, r_phi;
    logic [ACC_W-1:0]    r_acc;
    logic [63:0]         r_x, r_res, r_bit;
    logic                r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [CNT_W-1:0]    win_sz;
    logic [55:0]         ev_prod, wr_prod;
    logic [WSUM_W-1:0]   n_wsum;
    logic [VSUM_W-1:0]   n_vsum;
    logic [32:0]         rem2, rem_nx;
    logic                q_bit;
    logic [63:0]         dq_nx;
    logic [TP_W-1:0]     w_tp;
    logic [31:0]         w_d;
    logic [63:0]         w_sq;
    logic [63:0]         sq_trial;
    logic                walk_done;
    logic                out_free;
    logic [BAND_W-1:0]   b_v, b_d1, b_d2, b_d3;

    always_comb begin
        if (i_win == '0) begin
            win_sz = 9'd1;
        end else if (i_win > WIN_MAX) begin
            win_sz = WIN_MAX;
        end else begin
            win_sz = i_win;
        end
        ev_prod = {24'b0, r_rdata[55:24]} * {32'b0, r_rdata[23:0]};
        wr_prod = {24'b0, r_item.tp} * {32'b0, r_item.vol};
        n_wsum  = r_wsum + {8'b0, wr_prod};
        n_vsum  = r_vsum + {8'b0, r_item.vol};
        rem2    = {r_rem, r_dq[63]};
        q_bit   = (rem2 >= {1'b0, r_vsum});
        rem_nx  = q_bit ? (rem2 - {1'b0, r_vsum}) : rem2;
        dq_nx   = {r_dq[62:0], q_bit};
        w_tp    = r_rdata[55:24];
        w_d     = (w_tp >= r_vwap) ? (w_tp - r_vwap) : (r_vwap - w_tp);
        w_sq    = {32'b0, w_d} * {32'b0, w_d};
        sq_trial = r_res + r_bit;
        walk_done = (r_cnt == r_fill) && !r_v1 && !r_v2 && !r_v3;
        out_free = !r_ovalid || m_axis_tready;
        b_v  = {3'b0, r_vwap};
        b_d1 = {3'b0, r_dev};
        b_d2 = {2'b0, r_dev, 1'b0};
        b_d3 = b_d1 + b_d2;
    end

    always_comb begin
        case (r_state)
            S_EVRD:  rd_addr = r_wpos - r_fill[RING_AW-1:0];
            S_WALK:  rd_addr = r_wpos - r_fill[RING_AW-1:0] + r_cnt[RING_AW-1:0];
            default: rd_addr = r_wpos;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_q_stat.empty) n_state = S_EVRD;
            S_EVRD: n_state = (r_fill >= r_size) ? S_EVUP : S_WR;
            S_EVUP: n_state = S_EVRD;
            S_WR:   n_state = S_DIV1;
            S_DIV1: begin
                if (r_vsum == '0) begin
                    n_state = S_OUT;
                end else if (r_cnt == DIV_LAST) begin
                    n_state = (r_fill > 9'd1) ? S_WALK : S_OUT;
                end
            end
            S_WALK: if (walk_done) n_state = S_DIV2;
            S_DIV2: if (r_cnt == DIV_LAST) n_state = S_SQRT;
            S_SQRT: if (r_bit == '0) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_ring[rd_addr];
        if (r_state == S_WR) begin
            r_ring[r_wpos] <= {r_item.tp, r_item.vol};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wsum   <= '0;
            r_vsum   <= '0;
            r_fill   <= '0;
            r_wpos   <= '0;
            r_cnt    <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_item <= i_item;
                        r_size <= win_sz;
                        if (i_item.start) begin
                            r_wsum <= '0;
                            r_vsum <= '0;
                            r_fill <= '0;
                            r_wpos <= '0;
                        end
                    end
                end
                S_EVUP: begin
                    r_wsum <= r_wsum - {8'b0, ev_prod};
                    r_vsum <= r_vsum - {8'b0, r_rdata[23:0]};
                    r_fill <= r_fill - 9'd1;
                end
                S_WR: begin
                    r_wsum <= n_wsum;
                    r_vsum <= n_vsum;
                    r_fill <= r_fill + 9'd1;
                    r_wpos <= r_wpos + 8'd1;
                    r_dq   <= n_wsum;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end
                S_DIV1: begin
                    r_rem <= rem_nx[31:0];
                    r_dq  <= dq_nx;
                    r_dev <= '0;
                    if (r_vsum == '0) begin
                        r_vwap <= '0;
                        r_cnt  <= r_cnt + 9'd1;
                    end else if (r_cnt == DIV_LAST) begin
                        r_vwap <= dq_nx[31:0];
                        r_cnt  <= '0;
                        r_acc  <= '0;
                        r_v1   <= 1'b0;
                        r_v2   <= 1'b0;
                        r_v3   <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + 9'd1;
                    end
                end
                S_WALK: begin
                    r_v1 <= (r_cnt != r_fill);
                    if (r_cnt != r_fill) begin
                        r_cnt <= r_cnt + 9'd1;
                    end
                    r_v2   <= r_v1;
                    r_sq   <= w_sq;
                    r_vol2 <= r_rdata[23:0];
                    r_v3   <= r_v2;
                    r_plo  <= {24'b0, r_sq[31:0]} * {32'b0, r_vol2};
                    r_phi  <= {24'b0, r_sq[63:32]} * {32'b0, r_vol2};
                    if (r_v3) begin
                        r_acc <= r_acc + {40'b0, r_plo} + {8'b0, r_phi, 32'b0};
                    end
                    if (walk_done) begin
                        r_rem <= r_acc[95:64];
                        r_dq  <= r_acc[63:0];
                        r_cnt <= '0;
                    end
                end
                S_DIV2: begin
                    r_rem <= rem_nx[31:0];
                    r_dq  <= dq_nx;
                    r_cnt <= r_cnt + 9'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_x   <= dq_nx;
                        r_res <= '0;
                        r_bit <= 64'h4000_0000_0000_0000;
                    end
                end
                S_SQRT: begin
                    if (r_bit != '0) begin
                        if (r_x >= sq_trial) begin
                            r_x   <= r_x - sq_trial;
                            r_res <= {1'b0, r_res[63:1]} + r_bit;
                        end else begin
                            r_res <= {1'b0, r_res[63:1]};
                        end
                        r_bit <= {2'b0, r_bit[63:2]};
                    end else begin
                        r_dev <= r_res[31:0];
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_odata  <= {6'b0,
                                     b_v - b_d3, b_v + b_d3,
                                     b_v - b_d2, b_v + b_d2,
                                     b_v - b_d1, b_v + b_d1,
                                     r_vwap};
                    end
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
`default_nettype wire

/* src/rolling_vwap_with_deviation_bands_core.sv */
// Top level: rolling VWAP with volume-weighted deviation bands.
// Latency grows with the bars in the window after the insert and with each evicted bar;
//   a lone bar skips the walk, second divide and sqrt; zero volume ends the first divide at once.
// Throughput: one bar at a time, set by two 64-step divides, the walk and a bit-serial sqrt.
// Reset: synchronous active low; clears sums, fill count, queue and handshakes,
//   window size returns to 20; ring contents are not cleared.
`default_nettype none
module rolling_vwap_with_deviation_bands_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [rvwap_pkg::CNT_W-1:0]        i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // high_price, low_price, close_price, bar_volume
    input  logic [rvwap_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // series_start
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // vwap, band1_upper, band1_lower, band2_upper, band2_lower, band3_upper, band3_lower
    output logic [rvwap_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import rvwap_pkg::*;

    logic [CNT_W-1:0] r_window_size;
    t_item            push_item, q_item;
    t_q_stat          q_stat;
    logic             push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_window_size <= i_cfg_wr_data;
        end
    end

    rvwap_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_item        (push_item)
    );

    rvwap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    rvwap_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_win         (r_window_size),
        .i_item        (q_item),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );
endmodule
`default_nettype wire

/* dv/rolling_vwap_with_deviation_bands_core_test.sv */
// Testbench for the rolling VWAP band core: random price bars checked against a VWAP predictor.
`timescale 1ns / 100ps
module rolling_vwap_with_deviation_bands_core_test;
    import rvwap_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int MAX_BARS       = 4096;

    typedef struct packed {
        logic        start;
        logic [23:0] high_p;
        logic [23:0] low_p;
        logic [23:0] close_p;
        logic [23:0] volume;
    } bar_t;

    typedef struct packed {
        logic [34:0] b3_lo;
        logic [34:0] b3_hi;
        logic [34:0] b2_lo;
        logic [34:0] b2_hi;
        logic [34:0] b1_lo;
        logic [34:0] b1_hi;
        logic [31:0] vwap;
    } bands_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CNT_W-1:0]      i_cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    rolling_vwap_with_deviation_bands_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic [31:0] ring_tp  [RING_DEPTH];
    logic [23:0] ring_vol [RING_DEPTH];
    logic [63:0] price_vol_sum;
    logic [31:0] vol_sum;
    int          fill_cnt;
    int          wr_pos;
    int          win_len;

    bar_t   pending_bars [MAX_BARS];
    int     pend_head;
    int     pend_tail;
    bands_t expected_bands [MAX_BARS];
    int     exp_head;
    int     exp_tail;
    logic   in_taken;
    int     send_idle;
    int     recv_idle;
    int     mismatches;
    int     bars_sent;
    int     bars_checked;
    int     stall_cycles;
    logic [23:0] base_price;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = x;
        root = 64'd0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic bands_t predict_bands(input bar_t b);
        bands_t      r;
        logic [33:0] tp_full;
        logic [31:0] tp;
        logic [63:0] vw;
        logic [63:0] dev;
        logic [63:0] d;
        logic [127:0] acc;
        logic [127:0] quo;
        int          old;
        int          idx;
        int          size;
        size = (win_len == 0) ? 1 : (win_len > 256 ? 256 : win_len);
        if (b.start) begin
            price_vol_sum = 0;
            vol_sum       = 0;
            fill_cnt      = 0;
            wr_pos        = 0;
        end
        while (fill_cnt >= size) begin
            old = (wr_pos + 256 - fill_cnt) % 256;
            price_vol_sum = price_vol_sum - 64'(ring_tp[old]) * 64'(ring_vol[old]);
            vol_sum = vol_sum - 32'(ring_vol[old]);
            fill_cnt--;
        end
        tp_full = ((34'(b.high_p) + 34'(b.low_p) + 34'(b.close_p)) << 8) / 34'd3;
        tp = tp_full[31:0];
        ring_tp[wr_pos]  = tp;
        ring_vol[wr_pos] = b.volume;
        price_vol_sum = price_vol_sum + 64'(tp) * 64'(b.volume);
        vol_sum = vol_sum + 32'(b.volume);
        fill_cnt++;
        wr_pos = (wr_pos + 1) % 256;
        vw  = 0;
        dev = 0;
        if (vol_sum != 0) begin
            vw = {32'd0, 32'(price_vol_sum / 64'(vol_sum))};
            if (fill_cnt > 1) begin
                acc = 0;
                old = (wr_pos + 256 - fill_cnt) % 256;
                for (int i = 0; i < fill_cnt; i++) begin
                    idx = (old + i) % 256;
                    d = (64'(ring_tp[idx]) >= vw) ? 64'(ring_tp[idx]) - vw
                                                  : vw - 64'(ring_tp[idx]);
                    acc = acc + 128'(d * d) * 128'(ring_vol[idx]);
                end
                quo = acc / 128'(vol_sum);
                dev = int_sqrt(quo[63:0]);
            end
        end
        r.vwap  = vw[31:0];
        r.b1_hi = 35'(vw + dev);
        r.b1_lo = 35'(vw - dev);
        r.b2_hi = 35'(vw + 2 * dev);
        r.b2_lo = 35'(vw - 2 * dev);
        r.b3_hi = 35'(vw + 3 * dev);
        r.b3_lo = 35'(vw - 3 * dev);
        return r;
    endfunction

    function automatic bar_t random_bar();
        bar_t        b;
        logic [23:0] spread;
        int          kind;
        kind = $urandom_range(99);
        b.start = ($urandom_range(99) < 4);
        if (kind < 70) begin
            if ($urandom_range(99) < 3) base_price = 24'($urandom);
            spread    = 24'($urandom_range(4095));
            b.low_p   = (base_price > spread) ? base_price - spread : 24'd0;
            b.high_p  = (base_price < 24'hFFFFFF - spread) ? base_price + spread : 24'hFFFFFF;
            b.close_p = 24'($urandom_range(b.high_p, b.low_p));
            b.volume  = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(65535));
            base_price = b.close_p;
        end else if (kind < 88) begin
            b.high_p  = 24'($urandom);
            b.low_p   = 24'($urandom);
            b.close_p = 24'($urandom);
            b.volume  = 24'($urandom);
        end else if (kind < 94) begin
            b.high_p  = 24'($urandom);
            b.low_p   = 24'($urandom);
            b.close_p = 24'($urandom);
            b.volume  = 24'd0;
        end else begin
            b.high_p  = ($urandom_range(1)) ? 24'hFFFFFF : 24'd0;
            b.low_p   = ($urandom_range(1)) ? 24'hFFFFFF : 24'd0;
            b.close_p = ($urandom_range(1)) ? 24'hFFFFFF : 24'd0;
            b.volume  = ($urandom_range(1)) ? 24'hFFFFFF : 24'd1;
        end
        return b;
    endfunction

    function automatic bar_t make_bar(input logic st, input logic [23:0] h, l, c, v);
        bar_t b;
        b.start   = st;
        b.high_p  = h;
        b.low_p   = l;
        b.close_p = c;
        b.volume  = v;
        return b;
    endfunction

    function automatic void queue_bar(input bar_t b);
        pending_bars[pend_tail] = b;
        pend_tail = pend_tail + 1;
    endfunction

    task automatic wait_idle();
        while (bars_checked < pend_tail)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_window(input int value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CNT_W'(value);
        win_len = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // driver
    always @(negedge i_clk) begin
        bar_t b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pend_tail != pend_head && $urandom_range(99) >= send_idle) begin
                b = pending_bars[pend_head];
                pend_head = pend_head + 1;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {b.volume, b.close_p, b.low_p, b.high_p};
                s_axis_tuser  <= b.start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    // monitor
    always @(posedge i_clk) begin
        bar_t        b;
        bands_t      want;
        logic [241:0] got;
        logic [34:0] fw;
        logic [34:0] fg;
        logic        bad;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            b.start   = s_axis_tuser;
            b.high_p  = s_axis_tdata[23:0];
            b.low_p   = s_axis_tdata[47:24];
            b.close_p = s_axis_tdata[71:48];
            b.volume  = s_axis_tdata[95:72];
            expected_bands[exp_tail] = predict_bands(b);
            exp_tail = exp_tail + 1;
            bars_sent++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[241:0];
            if (exp_tail == exp_head) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", got);
            end else begin
                want = expected_bands[exp_head];
                exp_head = exp_head + 1;
                bars_checked++;
                for (int k = 0; k < 7; k++) begin
                    fw = (k == 0) ? 35'(want.vwap) : 35'(want >> (32 + 35 * (k - 1)));
                    fg = (k == 0) ? 35'(got[31:0]) : 35'(got >> (32 + 35 * (k - 1)));
                    bad = (k == 0) ? (fw[31:0] != fg[31:0]) : (fw != fg);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d field %0d: expected %h, got %h",
                                     bars_checked, k, fw, fg);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", exp_tail - exp_head);
            $display("rolling_vwap_with_deviation_bands_core_test: errors");
            $finish;
        end
    end

    initial begin
        int win_seq [9];
        int cnt_seq [9];
        int send_seq [3];
        int recv_seq [3];
        win_seq  = '{1, 256, 5, 2, 64, 17, 256, 3, 9};
        cnt_seq  = '{120, 260, 200, 200, 250, 250, 150, 200, 150};
        send_seq = '{29, 85, 0};
        recv_seq = '{85, 29, 0};
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        in_taken      = 1'b0;
        pend_head     = 0;
        pend_tail     = 0;
        exp_head      = 0;
        exp_tail      = 0;
        send_idle     = 29;
        recv_idle     = 85;
        mismatches    = 0;
        bars_sent     = 0;
        bars_checked  = 0;
        stall_cycles  = 0;
        base_price    = 24'd1000000;
        win_len       = 20;
        price_vol_sum = 0;
        vol_sum       = 0;
        fill_cnt      = 0;
        wr_pos        = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero volume, single bar, extremes, series restarts
        queue_bar(make_bar(1'b0, 24'd500, 24'd400, 24'd450, 24'd0));
        queue_bar(make_bar(1'b0, 24'd510, 24'd490, 24'd500, 24'd100));
        queue_bar(make_bar(1'b1, 24'd1200, 24'd1100, 24'd1150, 24'd77));
        queue_bar(make_bar(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        queue_bar(make_bar(1'b0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF));
        queue_bar(make_bar(1'b0, 24'hFFFFFF, 24'd0, 24'h800000, 24'd1));
        queue_bar(make_bar(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        queue_bar(make_bar(1'b1, 24'd0, 24'd0, 24'd0, 24'd0));
        queue_bar(make_bar(1'b0, 24'd3, 24'd1, 24'd2, 24'd0));
        queue_bar(make_bar(1'b1, 24'h0000FF, 24'h0000F0, 24'h0000F8, 24'd1));
        queue_bar(make_bar(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1));
        queue_bar(make_bar(1'b0, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA));
        queue_bar(make_bar(1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555));
        for (int i = 0; i < 8; i++)
            queue_bar(make_bar(1'b0, 24'($urandom), 24'($urandom),
                               24'($urandom), 24'hFFFFFF));

        for (int p = 0; p < 9; p++) begin
            set_window(win_seq[p]);
            send_idle = send_seq[(p / 3) % 3];
            recv_idle = recv_seq[(p / 3) % 3];
            for (int i = 0; i < cnt_seq[p]; i++)
                queue_bar(random_bar());
        end

        wait_idle();
        $display("checked %0d of %0d bars over 10 window settings (1 to 256),",
                 bars_checked, bars_sent);
        $display("including restarts, zero volume, extreme prices and window shrinks");
        if (mismatches == 0) begin
            $display("rolling_vwap_with_deviation_bands_core_test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("rolling_vwap_with_deviation_bands_core_test: errors");
        end
        $finish;
    end
endmodule
